// ===== sv/imu_lever_arm_accel_fusion_macros.svh =====
// Assertion macros shared by the checkers of the lever-arm fusion block.
// Depends on nothing; take it in with an include of the bare file name.
`ifndef IMU_LEVER_ARM_ACCEL_FUSION_MACROS_SVH
`define IMU_LEVER_ARM_ACCEL_FUSION_MACROS_SVH

// Implication in the same cycle, switched off while reset is held.
`define LAF_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Implication into the next cycle, checked during reset as well.
`define LAF_ASSERT_NEXT(label, clk, ante, cons, msg) \
    label: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/imu_laf_pkg.sv =====
// Constants and arithmetic helpers for the IMU lever-arm fusion block.
// Used by the top level and its checker; depends on nothing.
package imu_laf_pkg;

    localparam int DATA_WIDTH_DEF = 32;
    localparam int ADDR_W         = 5;
    localparam int NUM_ARMS       = 6;
    localparam int ARM_W          = 24;

    // Register indexes, one per lever-arm component.
    localparam logic [2:0] REG_ARM1_X = 3'd0;
    localparam logic [2:0] REG_ARM1_Y = 3'd1;
    localparam logic [2:0] REG_ARM1_Z = 3'd2;
    localparam logic [2:0] REG_ARM2_X = 3'd3;
    localparam logic [2:0] REG_ARM2_Y = 3'd4;
    localparam logic [2:0] REG_ARM2_Z = 3'd5;

    // Reset lever arms in Q8.16 metres.
    localparam logic signed [ARM_W-1:0] ARM1_X_RST = 24'sd78643;
    localparam logic signed [ARM_W-1:0] ARM1_Y_RST = 24'sd4850;
    localparam logic signed [ARM_W-1:0] ARM1_Z_RST = -24'sd1769;
    localparam logic signed [ARM_W-1:0] ARM2_X_RST = 24'sd78643;
    localparam logic signed [ARM_W-1:0] ARM2_Y_RST = 24'sd4260;
    localparam logic signed [ARM_W-1:0] ARM2_Z_RST = 24'sd3080;

    typedef logic signed [31:0] t_q16;
    typedef logic signed [55:0] t_prod1;
    typedef logic signed [63:0] t_prod2;
    typedef logic signed [49:0] t_corr;

    // Difference of two Q.32 products, rounded half up to Q.16 and
    // saturated to 32 bits.
    function automatic t_q16 f_cross1(input t_prod1 a, input t_prod1 b);
        logic signed [56:0] diff;
        logic signed [56:0] tmp;
        logic signed [40:0] rnd;
        diff = {a[55], a} - {b[55], b};
        tmp  = diff + 57'sd32768;
        rnd  = tmp[56:16];
        if ((&rnd[40:31]) || !(|rnd[40:31])) begin
            return rnd[31:0];
        end else if (rnd[40]) begin
            return 32'sh8000_0000;
        end else begin
            return 32'sh7fff_ffff;
        end
    endfunction

    // Q.32 product rounded half up to Q.16.
    function automatic logic signed [47:0] f_round16(input t_prod2 p);
        logic signed [63:0] tmp;
        tmp = p + 64'sd32768;
        return tmp[63:16];
    endfunction

endpackage

// ===== sv/imu_lever_arm_accel_fusion.sv =====
// Top level of the IMU lever-arm compensation and two-IMU fusion datapath.
// Depends on imu_laf_pkg for constants, reset values and rounding helpers.
//
// Usage:
//   Input words (body rate, two accelerometer vectors, two dead flags) enter
//   on i_in_valid and are taken at each edge where o_in_stall is low.
//   Result words (fused x, y, z) leave on o_out_valid and are taken at each
//   edge where i_out_stall is low.
//   The lever arms sit in six APB registers at byte addresses 0 to 20; they
//   are to be written only while no word is in flight; the block does not
//   enforce this itself. pready is always high. A word passes through the
//   stage registers in order before o_out_valid rises. One word enters and one
//   leaves each cycle, unless a stall holds them, through the five-stage pipeline:
//   first cross products, first rounding, second cross products, rounding and correction,
//   then averaging (or the one live reading, or zero) and saturation. Each stage
//   holds its word while the one after it is full and stalled, so a stall at the
//   output backs up stage by stage to o_in_stall without losing or repeating a word.
//   Reset empties the pipeline and returns the lever arms to their defaults.
module imu_lever_arm_accel_fusion #(
    parameter int DATA_WIDTH = imu_laf_pkg::DATA_WIDTH_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // APB-style configuration port
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [imu_laf_pkg::ADDR_W-1:0]    paddr,
    input  logic [31:0]                       pwdata,
    output logic [31:0]                       prdata,
    output logic                              pready,
    // input channel
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  logic signed [31:0]                i_rate_x,
    input  logic signed [31:0]                i_rate_y,
    input  logic signed [31:0]                i_rate_z,
    input  logic signed [31:0]                i_accel1_x,
    input  logic signed [31:0]                i_accel1_y,
    input  logic signed [31:0]                i_accel1_z,
    input  logic signed [31:0]                i_accel2_x,
    input  logic signed [31:0]                i_accel2_y,
    input  logic signed [31:0]                i_accel2_z,
    input  logic                              i_imu1_dead,
    input  logic                              i_imu2_dead,
    // output channel
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output logic signed [31:0]                o_fused_x,
    output logic signed [31:0]                o_fused_y,
    output logic signed [31:0]                o_fused_z
);

    localparam int NSTAGE = 5;
    localparam int CORR_W = 50;
    localparam logic signed [CORR_W-1:0] SAT_HI =
        {{(CORR_W-DATA_WIDTH+1){1'b0}}, {(DATA_WIDTH-1){1'b1}}};
    localparam logic signed [CORR_W-1:0] SAT_LO = ~SAT_HI;

    // ---------------------------------------------------------------- config
    logic signed [imu_laf_pkg::ARM_W-1:0] r_arm [imu_laf_pkg::NUM_ARMS];
    logic [2:0] cfg_idx;
    logic       cfg_wr;

    assign cfg_idx = paddr[4:2];
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign pready  = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_arm[imu_laf_pkg::REG_ARM1_X] <= imu_laf_pkg::ARM1_X_RST;
            r_arm[imu_laf_pkg::REG_ARM1_Y] <= imu_laf_pkg::ARM1_Y_RST;
            r_arm[imu_laf_pkg::REG_ARM1_Z] <= imu_laf_pkg::ARM1_Z_RST;
            r_arm[imu_laf_pkg::REG_ARM2_X] <= imu_laf_pkg::ARM2_X_RST;
            r_arm[imu_laf_pkg::REG_ARM2_Y] <= imu_laf_pkg::ARM2_Y_RST;
            r_arm[imu_laf_pkg::REG_ARM2_Z] <= imu_laf_pkg::ARM2_Z_RST;
        end else if (cfg_wr && (cfg_idx < 3'(imu_laf_pkg::NUM_ARMS))) begin
            r_arm[cfg_idx] <= pwdata[imu_laf_pkg::ARM_W-1:0];
        end
    end

    always_comb begin
        case (cfg_idx)
            imu_laf_pkg::REG_ARM1_X: prdata = {8'd0, r_arm[imu_laf_pkg::REG_ARM1_X]};
            imu_laf_pkg::REG_ARM1_Y: prdata = {8'd0, r_arm[imu_laf_pkg::REG_ARM1_Y]};
            imu_laf_pkg::REG_ARM1_Z: prdata = {8'd0, r_arm[imu_laf_pkg::REG_ARM1_Z]};
            imu_laf_pkg::REG_ARM2_X: prdata = {8'd0, r_arm[imu_laf_pkg::REG_ARM2_X]};
            imu_laf_pkg::REG_ARM2_Y: prdata = {8'd0, r_arm[imu_laf_pkg::REG_ARM2_Y]};
            imu_laf_pkg::REG_ARM2_Z: prdata = {8'd0, r_arm[imu_laf_pkg::REG_ARM2_Z]};
            default:                 prdata = 32'd0;
        endcase
    end

    // ------------------------------------------------------------ flow control
    logic [NSTAGE-1:0] r_vld;
    logic [NSTAGE-1:0] n_vld;
    logic [NSTAGE-1:0] rdy;

    // A stage may load when it is empty or its word moves on this cycle.
    always_comb begin
        rdy[4] = !r_vld[4] || !i_out_stall;
        rdy[3] = !r_vld[3] || rdy[4];
        rdy[2] = !r_vld[2] || rdy[3];
        rdy[1] = !r_vld[1] || rdy[2];
        rdy[0] = !r_vld[0] || rdy[1];
        n_vld[0] = rdy[0] ? i_in_valid : r_vld[0];
        n_vld[1] = rdy[1] ? r_vld[0]   : r_vld[1];
        n_vld[2] = rdy[2] ? r_vld[1]   : r_vld[2];
        n_vld[3] = rdy[3] ? r_vld[2]   : r_vld[3];
        n_vld[4] = rdy[4] ? r_vld[3]   : r_vld[4];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= n_vld;
        end
    end

    assign o_in_stall  = !rdy[0];
    assign o_out_valid = r_vld[4];

    // ------------------------------------------- stage 1: products of w and d
    imu_laf_pkg::t_q16   in_w [3];
    imu_laf_pkg::t_q16   in_a [2][3];
    imu_laf_pkg::t_prod1 n1_pa [2][3];
    imu_laf_pkg::t_prod1 n1_pb [2][3];
    imu_laf_pkg::t_prod1 r1_pa [2][3];
    imu_laf_pkg::t_prod1 r1_pb [2][3];
    imu_laf_pkg::t_q16   r1_w [3];
    imu_laf_pkg::t_q16   r1_a [2][3];
    logic [1:0]          r1_dead;

    assign in_w[0]    = i_rate_x;
    assign in_w[1]    = i_rate_y;
    assign in_w[2]    = i_rate_z;
    assign in_a[0][0] = i_accel1_x;
    assign in_a[0][1] = i_accel1_y;
    assign in_a[0][2] = i_accel1_z;
    assign in_a[1][0] = i_accel2_x;
    assign in_a[1][1] = i_accel2_y;
    assign in_a[1][2] = i_accel2_z;

    always_comb begin
        for (int m = 0; m < 2; m++) begin
            n1_pa[m][0] = in_w[1] * r_arm[3*m+2];
            n1_pb[m][0] = in_w[2] * r_arm[3*m+1];
            n1_pa[m][1] = in_w[2] * r_arm[3*m+0];
            n1_pb[m][1] = in_w[0] * r_arm[3*m+2];
            n1_pa[m][2] = in_w[0] * r_arm[3*m+1];
            n1_pb[m][2] = in_w[1] * r_arm[3*m+0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy[0]) begin
            r1_pa   <= n1_pa;
            r1_pb   <= n1_pb;
            r1_w    <= in_w;
            r1_a    <= in_a;
            r1_dead <= {i_imu2_dead, i_imu1_dead};
        end
    end

    // --------------------------------------- stage 2: round first cross w x d
    imu_laf_pkg::t_q16 n2_v [2][3];
    imu_laf_pkg::t_q16 r2_v [2][3];
    imu_laf_pkg::t_q16 r2_w [3];
    imu_laf_pkg::t_q16 r2_a [2][3];
    logic [1:0]        r2_dead;

    always_comb begin
        for (int m = 0; m < 2; m++) begin
            for (int i = 0; i < 3; i++) begin
                n2_v[m][i] = imu_laf_pkg::f_cross1(r1_pa[m][i], r1_pb[m][i]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy[1]) begin
            r2_v    <= n2_v;
            r2_w    <= r1_w;
            r2_a    <= r1_a;
            r2_dead <= r1_dead;
        end
    end

    // ------------------------------------------- stage 3: products of w and v
    imu_laf_pkg::t_prod2 n3_qa [2][3];
    imu_laf_pkg::t_prod2 n3_qb [2][3];
    imu_laf_pkg::t_prod2 r3_qa [2][3];
    imu_laf_pkg::t_prod2 r3_qb [2][3];
    imu_laf_pkg::t_q16   r3_a [2][3];
    logic [1:0]          r3_dead;

    always_comb begin
        for (int m = 0; m < 2; m++) begin
            n3_qa[m][0] = r2_w[1] * r2_v[m][2];
            n3_qb[m][0] = r2_w[2] * r2_v[m][1];
            n3_qa[m][1] = r2_w[2] * r2_v[m][0];
            n3_qb[m][1] = r2_w[0] * r2_v[m][2];
            n3_qa[m][2] = r2_w[0] * r2_v[m][1];
            n3_qb[m][2] = r2_w[1] * r2_v[m][0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy[2]) begin
            r3_qa   <= n3_qa;
            r3_qb   <= n3_qb;
            r3_a    <= r2_a;
            r3_dead <= r2_dead;
        end
    end

    // ------------------------- stage 4: round products, subtract from reading
    imu_laf_pkg::t_corr n4_c [2][3];
    imu_laf_pkg::t_corr r4_c [2][3];
    logic [1:0]         r4_dead;

    always_comb begin
        logic signed [47:0] ra;
        logic signed [47:0] rb;
        logic signed [48:0] cen;
        for (int m = 0; m < 2; m++) begin
            for (int i = 0; i < 3; i++) begin
                ra  = imu_laf_pkg::f_round16(r3_qa[m][i]);
                rb  = imu_laf_pkg::f_round16(r3_qb[m][i]);
                cen = {ra[47], ra} - {rb[47], rb};
                n4_c[m][i] = {{18{r3_a[m][i][31]}}, r3_a[m][i]} - {cen[48], cen};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy[3]) begin
            r4_c    <= n4_c;
            r4_dead <= r3_dead;
        end
    end

    // ------------------------------------ stage 5: fuse, saturate and output
    imu_laf_pkg::t_q16 n5_f [3];
    imu_laf_pkg::t_q16 r5_f [3];

    always_comb begin
        logic signed [CORR_W:0]   sum;
        logic signed [CORR_W-1:0] fused;
        for (int i = 0; i < 3; i++) begin
            sum = {r4_c[0][i][CORR_W-1], r4_c[0][i]}
                + {r4_c[1][i][CORR_W-1], r4_c[1][i]} + 51'sd1;
            case (r4_dead)
                2'b00:   fused = sum[CORR_W:1];
                2'b10:   fused = r4_c[0][i];
                2'b01:   fused = r4_c[1][i];
                default: fused = '0;
            endcase
            if (fused > SAT_HI) begin
                fused = SAT_HI;
            end else if (fused < SAT_LO) begin
                fused = SAT_LO;
            end
            n5_f[i] = fused[31:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy[4]) begin
            r5_f <= n5_f;
        end
    end

    assign o_fused_x = r5_f[0];
    assign o_fused_y = r5_f[1];
    assign o_fused_z = r5_f[2];

endmodule

// ===== sv/imu_laf_checker.sv =====
// Port-level checker for the IMU lever-arm fusion block, with its bind.
// Depends on imu_lever_arm_accel_fusion_macros.svh for the assertion macros.
`include "imu_lever_arm_accel_fusion_macros.svh"

module imu_laf_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_in_stall,
    input logic        o_out_valid,
    input logic        i_out_stall,
    input logic [31:0] o_fused_x,
    input logic [31:0] o_fused_y,
    input logic [31:0] o_fused_z
);

    // A stalled result word stays on the port unchanged.
    `LAF_ASSERT_NOW(a_out_hold, i_clk, i_rst_n, o_out_valid && i_out_stall ##1 1'b1, o_out_valid && $stable(o_fused_x) && $stable(o_fused_y) && $stable(o_fused_z), "stalled result word changed")

    // The pipeline only pushes back when the output side holds a stalled word.
    `LAF_ASSERT_NOW(a_stall_source, i_clk, i_rst_n, o_in_stall, o_out_valid && i_out_stall, "input stalled without an output stall")

    // Reset empties the pipeline.
    `LAF_ASSERT_NEXT(a_reset_empty, i_clk, !i_rst_n, !o_out_valid && !o_in_stall, "pipeline not empty after reset")

endmodule

bind imu_lever_arm_accel_fusion imu_laf_checker u_imu_laf_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_fused_x   (o_fused_x),
    .o_fused_y   (o_fused_y),
    .o_fused_z   (o_fused_z)
);

// ===== test/imu_lever_arm_accel_fusion_check.sv =====
// Checker for the IMU lever-arm fusion block: follows the register writes,
// predicts each fused word on input acceptance and compares it on output.
// Depends on imu_laf_pkg for the register indexes and reset lever arms.
module imu_lever_arm_accel_fusion_check #(
    parameter int DATA_WIDTH = imu_laf_pkg::DATA_WIDTH_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [imu_laf_pkg::ADDR_W-1:0] paddr,
    input  logic [31:0]                    pwdata,
    input  logic                           pready,
    input  logic                           i_in_valid,
    input  logic                           o_in_stall,
    input  logic signed [31:0]             i_rate_x,
    input  logic signed [31:0]             i_rate_y,
    input  logic signed [31:0]             i_rate_z,
    input  logic signed [31:0]             i_accel1_x,
    input  logic signed [31:0]             i_accel1_y,
    input  logic signed [31:0]             i_accel1_z,
    input  logic signed [31:0]             i_accel2_x,
    input  logic signed [31:0]             i_accel2_y,
    input  logic signed [31:0]             i_accel2_z,
    input  logic                           i_imu1_dead,
    input  logic                           i_imu2_dead,
    input  logic                           o_out_valid,
    input  logic                           i_out_stall,
    input  logic signed [31:0]             o_fused_x,
    input  logic signed [31:0]             o_fused_y,
    input  logic signed [31:0]             o_fused_z,
    output int                             o_fail_count,
    output int                             o_pending,
    output int                             o_results_seen
);
    timeunit 1ns;
    timeprecision 1ps;

    logic signed [imu_laf_pkg::ARM_W-1:0] arm1_x, arm1_y, arm1_z;
    logic signed [imu_laf_pkg::ARM_W-1:0] arm2_x, arm2_y, arm2_z;

    // Expected fused words, {x, y, z}, oldest first.
    logic [95:0] fused_queue [$];
    logic [95:0] fused_exp;

    initial begin
        o_fail_count   = 0;
        o_pending      = 0;
        o_results_seen = 0;
    end

    task automatic report_mismatch(input string msg);
        $display("[%0t] mismatch: %s", $realtime, msg);
        o_fail_count = o_fail_count + 1;
    endtask

    function automatic longint clamp(input longint v, input int w);
        longint hi;
        longint lo;
        hi = (longint'(1) <<< (w - 1)) - 1;
        lo = -hi - 1;
        if (v > hi) begin
            return hi;
        end else if (v < lo) begin
            return lo;
        end
        return v;
    endfunction

    // Q.32 to Q.16, half an LSB added before an arithmetic shift.
    function automatic longint round16(input longint v);
        return (v + 32768) >>> 16;
    endfunction

    // Reading minus w x (w x d); returns {x, y, z} as 64-bit fields.
    function automatic logic [191:0] correct_imu(
        input longint wx, input longint wy, input longint wz,
        input longint dx, input longint dy, input longint dz,
        input longint ax, input longint ay, input longint az
    );
        longint vx, vy, vz;
        longint cx, cy, cz;
        vx = clamp(round16(wy * dz - wz * dy), 32);
        vy = clamp(round16(wz * dx - wx * dz), 32);
        vz = clamp(round16(wx * dy - wy * dx), 32);
        cx = round16(wy * vz) - round16(wz * vy);
        cy = round16(wz * vx) - round16(wx * vz);
        cz = round16(wx * vy) - round16(wy * vx);
        return {ax - cx, ay - cy, az - cz};
    endfunction

    function automatic logic [31:0] fuse_axis(input longint c1, input longint c2);
        longint r;
        if (!i_imu1_dead && !i_imu2_dead) begin
            r = (c1 + c2 + 1) >>> 1;
        end else if (!i_imu1_dead) begin
            r = c1;
        end else if (!i_imu2_dead) begin
            r = c2;
        end else begin
            r = 0;
        end
        r = clamp(r, DATA_WIDTH);
        return r[31:0];
    endfunction

    function automatic logic [95:0] predict_fused();
        logic [191:0] corr1;
        logic [191:0] corr2;
        corr1 = correct_imu(longint'(i_rate_x), longint'(i_rate_y), longint'(i_rate_z),
                            longint'(arm1_x), longint'(arm1_y), longint'(arm1_z),
                            longint'(i_accel1_x), longint'(i_accel1_y),
                            longint'(i_accel1_z));
        corr2 = correct_imu(longint'(i_rate_x), longint'(i_rate_y), longint'(i_rate_z),
                            longint'(arm2_x), longint'(arm2_y), longint'(arm2_z),
                            longint'(i_accel2_x), longint'(i_accel2_y),
                            longint'(i_accel2_z));
        return {fuse_axis(corr1[191:128], corr2[191:128]),
                fuse_axis(corr1[127:64], corr2[127:64]),
                fuse_axis(corr1[63:0], corr2[63:0])};
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            arm1_x <= imu_laf_pkg::ARM1_X_RST;
            arm1_y <= imu_laf_pkg::ARM1_Y_RST;
            arm1_z <= imu_laf_pkg::ARM1_Z_RST;
            arm2_x <= imu_laf_pkg::ARM2_X_RST;
            arm2_y <= imu_laf_pkg::ARM2_Y_RST;
            arm2_z <= imu_laf_pkg::ARM2_Z_RST;
            fused_queue.delete();
            o_pending <= 0;
        end else begin
            // Only the low 24 bits of a written value matter; unknown
            // indexes leave every lever arm alone.
            if (psel && penable && pwrite && pready) begin
                case (paddr[imu_laf_pkg::ADDR_W-1:2])
                    imu_laf_pkg::REG_ARM1_X: arm1_x <= pwdata[23:0];
                    imu_laf_pkg::REG_ARM1_Y: arm1_y <= pwdata[23:0];
                    imu_laf_pkg::REG_ARM1_Z: arm1_z <= pwdata[23:0];
                    imu_laf_pkg::REG_ARM2_X: arm2_x <= pwdata[23:0];
                    imu_laf_pkg::REG_ARM2_Y: arm2_y <= pwdata[23:0];
                    imu_laf_pkg::REG_ARM2_Z: arm2_z <= pwdata[23:0];
                    default: ;
                endcase
            end
            if (o_out_valid && !i_out_stall) begin
                o_results_seen = o_results_seen + 1;
                if (fused_queue.size() == 0) begin
                    report_mismatch($sformatf("unexpected word x=%h y=%h z=%h",
                                              o_fused_x, o_fused_y, o_fused_z));
                end else begin
                    fused_exp = fused_queue.pop_front();
                    if (o_fused_x !== fused_exp[95:64]) begin
                        report_mismatch($sformatf("fused_x got %h expected %h",
                                                  o_fused_x, fused_exp[95:64]));
                    end
                    if (o_fused_y !== fused_exp[63:32]) begin
                        report_mismatch($sformatf("fused_y got %h expected %h",
                                                  o_fused_y, fused_exp[63:32]));
                    end
                    if (o_fused_z !== fused_exp[31:0]) begin
                        report_mismatch($sformatf("fused_z got %h expected %h",
                                                  o_fused_z, fused_exp[31:0]));
                    end
                end
            end
            if (i_in_valid && !o_in_stall) begin
                fused_queue.push_back(predict_fused());
            end
            o_pending <= fused_queue.size();
        end
    end

endmodule

// ===== test/imu_lever_arm_accel_fusion_test.sv =====
// Top of the testbench for the IMU lever-arm fusion block: drives the APB
// port and both channels, and gives the verdict from the checker's count.
// Depends on imu_laf_pkg, the block and imu_lever_arm_accel_fusion_check.
module imu_lever_arm_accel_fusion_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT  = 200000;
    localparam int DRAIN_CYCLES = 12;
    localparam int RAND_SETS    = 8;
    localparam int SET_WORDS    = 50;

    // Indexes past the end of the register list.
    localparam logic [2:0] REG_SPARE_LO = 3'd6;
    localparam logic [2:0] REG_SPARE_HI = 3'd7;

    localparam logic [23:0] ARM_MAX = 24'h7f_ffff;
    localparam logic [23:0] ARM_MIN = 24'h80_0000;

    localparam logic [31:0] Q_MAX  = 32'h7fff_ffff;
    localparam logic [31:0] Q_MIN  = 32'h8000_0000;
    localparam logic [31:0] Q_ONE  = 32'h0001_0000;
    localparam logic [31:0] Q_NEG1 = 32'hffff_ffff;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic psel = 1'b0;
    logic penable = 1'b0;
    logic pwrite = 1'b0;
    logic [imu_laf_pkg::ADDR_W-1:0] paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic pready;
    logic i_in_valid = 1'b0;
    logic o_in_stall;
    logic signed [31:0] i_rate_x = '0, i_rate_y = '0, i_rate_z = '0;
    logic signed [31:0] i_accel1_x = '0, i_accel1_y = '0, i_accel1_z = '0;
    logic signed [31:0] i_accel2_x = '0, i_accel2_y = '0, i_accel2_z = '0;
    logic i_imu1_dead = 1'b0;
    logic i_imu2_dead = 1'b0;
    logic o_out_valid;
    logic i_out_stall = 1'b0;
    logic signed [31:0] o_fused_x, o_fused_y, o_fused_z;

    int fail_count;
    int pending;
    int results_seen;
    int cycle_count = 0;
    int words_sent = 0;
    int arm_settings = 0;
    int send_idle_pct = 0;
    int recv_idle_pct = 0;

    imu_lever_arm_accel_fusion DUT (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .i_in_valid(i_in_valid), .o_in_stall(o_in_stall),
        .i_rate_x(i_rate_x), .i_rate_y(i_rate_y), .i_rate_z(i_rate_z),
        .i_accel1_x(i_accel1_x), .i_accel1_y(i_accel1_y), .i_accel1_z(i_accel1_z),
        .i_accel2_x(i_accel2_x), .i_accel2_y(i_accel2_y), .i_accel2_z(i_accel2_z),
        .i_imu1_dead(i_imu1_dead), .i_imu2_dead(i_imu2_dead),
        .o_out_valid(o_out_valid), .i_out_stall(i_out_stall),
        .o_fused_x(o_fused_x), .o_fused_y(o_fused_y), .o_fused_z(o_fused_z)
    );

    imu_lever_arm_accel_fusion_check checker_inst (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .pready(pready),
        .i_in_valid(i_in_valid), .o_in_stall(o_in_stall),
        .i_rate_x(i_rate_x), .i_rate_y(i_rate_y), .i_rate_z(i_rate_z),
        .i_accel1_x(i_accel1_x), .i_accel1_y(i_accel1_y), .i_accel1_z(i_accel1_z),
        .i_accel2_x(i_accel2_x), .i_accel2_y(i_accel2_y), .i_accel2_z(i_accel2_z),
        .i_imu1_dead(i_imu1_dead), .i_imu2_dead(i_imu2_dead),
        .o_out_valid(o_out_valid), .i_out_stall(i_out_stall),
        .o_fused_x(o_fused_x), .o_fused_y(o_fused_y), .o_fused_z(o_fused_z),
        .o_fail_count(fail_count), .o_pending(pending), .o_results_seen(results_seen)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        i_out_stall <= ($urandom_range(99) < recv_idle_pct);
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Run timed out after %0d cycles.", cycle_count);
            $display("** imu_lever_arm_accel_fusion: FAILED **");
            $finish;
        end
    end

    // Called just after a rising edge; returns after the edge that wrote it.
    // The wait at the end keeps psel from being lowered and raised
    // within one step when writes follow each other.
    task automatic apb_write(input logic [2:0] idx, input logic [31:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
    endtask

    // Junk in the upper byte must be dropped by the register.
    task automatic write_arms(input logic [23:0] a1x, input logic [23:0] a1y,
                              input logic [23:0] a1z, input logic [23:0] a2x,
                              input logic [23:0] a2y, input logic [23:0] a2z);
        apb_write(imu_laf_pkg::REG_ARM1_X, {8'($urandom), a1x});
        apb_write(imu_laf_pkg::REG_ARM1_Y, {8'($urandom), a1y});
        apb_write(imu_laf_pkg::REG_ARM1_Z, {8'($urandom), a1z});
        apb_write(imu_laf_pkg::REG_ARM2_X, {8'($urandom), a2x});
        apb_write(imu_laf_pkg::REG_ARM2_Y, {8'($urandom), a2y});
        apb_write(imu_laf_pkg::REG_ARM2_Z, {8'($urandom), a2z});
        if ($urandom_range(1) == 0) begin
            apb_write(REG_SPARE_LO, $urandom);
        end else begin
            apb_write(REG_SPARE_HI, $urandom);
        end
        arm_settings++;
    endtask

    // Vectors are packed {x, y, z}. Returns at the edge of acceptance.
    task automatic send_word(input logic [95:0] rate, input logic [95:0] acc1,
                             input logic [95:0] acc2, input logic dead1,
                             input logic dead2);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        {i_rate_x, i_rate_y, i_rate_z}       <= rate;
        {i_accel1_x, i_accel1_y, i_accel1_z} <= acc1;
        {i_accel2_x, i_accel2_y, i_accel2_z} <= acc2;
        i_imu1_dead <= dead1;
        i_imu2_dead <= dead2;
        i_in_valid  <= 1'b1;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        words_sent++;
    endtask

    // The checker's pending count is registered, so look at it after the next edge.
    task automatic wait_drained();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
    endtask

    function automatic logic [31:0] signed_span(input int half);
        return int'($urandom_range(2 * half - 1)) - half;
    endfunction

    function automatic logic [31:0] rand_q16();
        case ($urandom_range(9))
            0: return Q_MAX;
            1: return Q_MIN;
            2: return 32'd0;
            3: return Q_NEG1;
            4, 5: return signed_span(1 << 20);
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [23:0] rand_arm(input int kind);
        case (kind)
            0: return 24'(signed_span(1 << 14));
            1: return 24'($urandom);
            2: begin
                case ($urandom_range(3))
                    0: return ARM_MAX;
                    1: return ARM_MIN;
                    2: return 24'd0;
                    default: return 24'($urandom);
                endcase
            end
            default: return 24'(signed_span(1 << 17));
        endcase
    endfunction

    task automatic send_random_word();
        logic [95:0] rate, acc1, acc2;
        logic dead1, dead2;
        int pick;
        // Mostly plausible flight data, the rest anything at all.
        if ($urandom_range(99) < 85) begin
            rate = {signed_span(1 << 19), signed_span(1 << 19), signed_span(1 << 19)};
            acc1 = {signed_span(1 << 22), signed_span(1 << 22), signed_span(1 << 22)};
            acc2 = {signed_span(1 << 22), signed_span(1 << 22), signed_span(1 << 22)};
        end else begin
            rate = {rand_q16(), rand_q16(), rand_q16()};
            acc1 = {rand_q16(), rand_q16(), rand_q16()};
            acc2 = {rand_q16(), rand_q16(), rand_q16()};
        end
        pick  = $urandom_range(9);
        dead1 = (pick == 0) || (pick == 2);
        dead2 = (pick == 1) || (pick == 2);
        send_word(rate, acc1, acc2, dead1, dead2);
    endtask

    task automatic send_extremes();
        send_word({Q_MAX, Q_MAX, Q_MAX}, {Q_MAX, Q_MAX, Q_MAX}, {Q_MAX, Q_MAX, Q_MAX},
                  1'b0, 1'b0);
        send_word({Q_MIN, Q_MIN, Q_MIN}, {Q_MIN, Q_MIN, Q_MIN}, {Q_MIN, Q_MIN, Q_MIN},
                  1'b0, 1'b0);
        send_word({Q_MAX, Q_MIN, Q_MAX}, {Q_MIN, Q_MIN, Q_MIN}, {Q_MAX, Q_MAX, Q_MAX},
                  1'b0, 1'b1);
        send_word({Q_MIN, Q_MAX, 32'd0}, {Q_MAX, Q_MIN, 32'd0}, {Q_MIN, Q_MAX, Q_NEG1},
                  1'b1, 1'b0);
        send_word({Q_MAX, Q_MAX, Q_MIN}, {Q_MAX, Q_MIN, Q_MAX}, {Q_MIN, Q_MAX, Q_MIN},
                  1'b1, 1'b1);
    endtask

    initial begin
        int phase;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed words on the reset lever arms.
        send_idle_pct = 32;
        recv_idle_pct = 62;
        arm_settings  = 1;
        send_word('0, '0, '0, 1'b0, 1'b0);
        send_word({Q_ONE, 32'd0, 32'd0}, {32'd0, 32'd0, 32'h0009_cf5c},
                  {32'd0, 32'd0, 32'h0009_cf5c}, 1'b0, 1'b0);
        send_word({32'h0000_8000, 32'hffff_b333, 32'h0002_0000},
                  {32'h0000_4000, 32'hfffe_0000, 32'h0009_cf5c},
                  {32'h0000_5000, 32'hfffe_1000, 32'h0009_d000}, 1'b0, 1'b0);
        send_word({32'h0000_8000, 32'hffff_b333, 32'h0002_0000},
                  {32'h0000_4000, 32'hfffe_0000, 32'h0009_cf5c},
                  {32'h0000_5000, 32'hfffe_1000, 32'h0009_d000}, 1'b1, 1'b0);
        send_word({32'h0000_8000, 32'hffff_b333, 32'h0002_0000},
                  {32'h0000_4000, 32'hfffe_0000, 32'h0009_cf5c},
                  {32'h0000_5000, 32'hfffe_1000, 32'h0009_d000}, 1'b0, 1'b1);
        send_word({32'h0000_8000, 32'hffff_b333, 32'h0002_0000},
                  {32'h0000_4000, 32'hfffe_0000, 32'h0009_cf5c},
                  {32'h0000_5000, 32'hfffe_1000, 32'h0009_d000}, 1'b1, 1'b1);
        // An odd sum of the two corrected readings exercises the halving.
        send_word({Q_NEG1, Q_NEG1, Q_NEG1}, {Q_NEG1, Q_NEG1, Q_NEG1},
                  {32'd0, 32'd0, 32'd0}, 1'b0, 1'b0);
        send_extremes();
        wait_drained();

        write_arms(ARM_MAX, ARM_MAX, ARM_MAX, ARM_MAX, ARM_MAX, ARM_MAX);
        send_extremes();
        send_word({Q_ONE, Q_NEG1, Q_ONE}, {32'd0, 32'd0, 32'd0}, {Q_ONE, Q_ONE, Q_ONE},
                  1'b0, 1'b0);
        wait_drained();

        write_arms(ARM_MIN, ARM_MIN, ARM_MIN, ARM_MIN, ARM_MIN, ARM_MIN);
        send_extremes();
        send_word({Q_NEG1, Q_ONE, Q_NEG1}, {Q_ONE, Q_ONE, Q_ONE}, {32'd0, 32'd0, 32'd0},
                  1'b0, 1'b0);
        wait_drained();

        for (int k = 0; k < RAND_SETS; k++) begin
            phase = (k * 3) / RAND_SETS;
            if (phase == 0) begin
                send_idle_pct = 32;
                recv_idle_pct = 62;
            end else if (phase == 1) begin
                send_idle_pct = 62;
                recv_idle_pct = 32;
            end else begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            write_arms(rand_arm(k % 4), rand_arm(k % 4), rand_arm(k % 4),
                       rand_arm(k % 4), rand_arm(k % 4), rand_arm(k % 4));
            for (int n = 0; n < SET_WORDS; n++) begin
                send_random_word();
            end
            wait_drained();
        end

        repeat (DRAIN_CYCLES) @(posedge i_clk);
        $display("Sent %0d words over %0d lever-arm settings and three stall mixes.",
                 words_sent, arm_settings);
        $display("Compared %0d fused results, %0d mismatches.", results_seen, fail_count);
        if (fail_count == 0) begin
            $display("** imu_lever_arm_accel_fusion: PASSED **");
        end else begin
            $display("** imu_lever_arm_accel_fusion: FAILED **");
        end
        $finish;
    end

endmodule
